// ----- hw/rtl/wies_pkg.sv -----
package wies_pkg;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OUI   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

  localparam logic [23:0] OUI_RESET   = 24'h0050f2;
  localparam logic [7:0]  LIMIT_RESET = 8'd128;

  localparam logic [1:0] PHASE_ID   = 2'd0;
  localparam logic [1:0] PHASE_LEN  = 2'd1;
  localparam logic [1:0] PHASE_DATA = 2'd2;

  localparam logic [7:0] ID_SSID      = 8'd0;
  localparam logic [7:0] ID_RATES     = 8'd1;
  localparam logic [7:0] ID_RSN       = 8'd48;
  localparam logic [7:0] ID_EXT_RATES = 8'd50;
  localparam logic [7:0] ID_VENDOR    = 8'd221;

  localparam logic [7:0] VENDOR_MIN_LEN = 8'd4;
  localparam logic [7:0] OUI_BYTES      = 8'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OPEN = 2'd1;
  localparam logic [1:0] STAT_STOP = 2'd2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] cur_id;
    logic [7:0] cur_len;
    logic [7:0] left;
    logic       oui_match;
    logic [5:0] pend_rate;
    logic [5:0] comm_rate;
    logic       security;
    logic       stopped;
  } run_t;

  typedef struct packed {
    logic ssid_clear;
    logic ssid_take;
  } ssid_op_t;

  localparam run_t RUN_RESET = '{
    phase:     PHASE_ID,
    cur_id:    8'd0,
    cur_len:   8'd0,
    left:      8'd0,
    oui_match: 1'b1,
    pend_rate: 6'd0,
    comm_rate: 6'd0,
    security:  1'b0,
    stopped:   1'b0
  };

endpackage

// ----- hw/rtl/wies_if.sv -----
interface wies_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elem_byte;
  logic       list_end;

  modport source (output valid, output elem_byte, output list_end, input ready);
  modport sink   (input valid, input elem_byte, input list_end, output ready);
endinterface

interface wies_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] ssid_char;
  logic [5:0] best_rate;
  logic       has_security;
  logic [5:0] ssid_length;
  logic [1:0] parse_status;
  logic       run_last;

  modport source (output valid, output item_kind, output ssid_char, output best_rate,
                  output has_security, output ssid_length, output parse_status,
                  output run_last, input ready);
  modport sink   (input valid, input item_kind, input ssid_char, input best_rate,
                  input has_security, input ssid_length, input parse_status,
                  input run_last, output ready);
endinterface

// ----- hw/rtl/wies_step.sv -----
module wies_step (
  input  wies_pkg::run_t     cur,
  input  logic [7:0]         b,
  input  logic [23:0]        vendor_oui,
  input  logic [7:0]         id_limit,
  output wies_pkg::run_t     nxt,
  output wies_pkg::ssid_op_t op
);
  import wies_pkg::*;

  logic [7:0] pos;
  logic [7:0] want;
  logic [5:0] rate;
  logic       fin;
  logic       is_rates;

  always_comb begin
    pos  = cur.cur_len - cur.left;
    rate = b[6:1];
    case (pos[1:0])
      2'd0:    want = vendor_oui[23:16];
      2'd1:    want = vendor_oui[15:8];
      default: want = vendor_oui[7:0];
    endcase
    is_rates = (cur.cur_id == ID_RATES) || (cur.cur_id == ID_EXT_RATES);
    nxt = cur;
    op  = '0;
    fin = 1'b0;
    if (!cur.stopped) begin
      case (cur.phase)
        PHASE_LEN: begin
          nxt.cur_len   = b;
          nxt.left      = b;
          op.ssid_clear = (cur.cur_id == ID_SSID);
          nxt.pend_rate = cur.comm_rate;
          nxt.oui_match = 1'b1;
          nxt.phase     = PHASE_DATA;
          fin           = (b == 8'd0);
        end
        PHASE_DATA: begin
          if (cur.cur_id == ID_SSID) begin
            op.ssid_take = 1'b1;
          end else if (is_rates) begin
            if (rate > cur.pend_rate) nxt.pend_rate = rate;
          end else if (cur.cur_id == ID_VENDOR && pos < OUI_BYTES && b != want) begin
            nxt.oui_match = 1'b0;
          end
          nxt.left = cur.left - 8'd1;
          fin      = (cur.left == 8'd1);
        end
        default: begin
          if (b >= id_limit && b != ID_VENDOR) begin
            nxt.stopped = 1'b1;
          end else begin
            nxt.cur_id = b;
            nxt.phase  = PHASE_LEN;
          end
        end
      endcase
      if (fin) begin
        nxt.phase = PHASE_ID;
        if (nxt.cur_id == ID_RATES || nxt.cur_id == ID_EXT_RATES) begin
          nxt.comm_rate = nxt.pend_rate;
        end else if (nxt.cur_id == ID_RSN) begin
          nxt.security = 1'b1;
        end else if (nxt.cur_id == ID_VENDOR && nxt.cur_len >= VENDOR_MIN_LEN &&
                     nxt.oui_match) begin
          nxt.security = 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/wifi_info_element_scanner_top.sv -----
// 802.11 information-element scanner. Takes the element list one byte per word on in_ch,
// one word per cycle, and keeps the SSID in an on-chip store of SSID_BYTES entries. The
// word marked list_end closes the run: the block then reads the SSID back out of the store
// through its single read port, one entry per cycle while out_ch does not stall, and sends
// n character words followed by one summary word on out_ch (n is the reported ssid_length,
// at most 32). in_ch is held off after a list_end word until those reads and the summary
// word have been issued, which takes longer while out_ch holds off the words already read;
// otherwise a byte is taken every cycle, also while a result still waits on out_ch. Registers
// vendor_oui (index 0) and id_limit (index 1) are written through cfg_we/cfg_idx/cfg_data.
module wifi_info_element_scanner_top #(
  parameter int SSID_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  wies_in_if.sink                         in_ch,
  wies_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [wies_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wies_pkg::CFG_W-1:0]      cfg_data
);
  import wies_pkg::*;

  localparam int CW       = $clog2(SSID_BYTES + 1);
  localparam int AW       = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;
  localparam int EMIT_MAX = (SSID_BYTES < 32) ? SSID_BYTES : 32;

  logic [23:0]   vendor_oui;
  logic [7:0]    id_limit;
  run_t          run;
  run_t          run_next;
  ssid_op_t      op;
  logic [CW-1:0] ssid_count;
  logic [CW-1:0] ssid_count_next;
  logic [7:0]    mem [SSID_BYTES];
  logic [7:0]    rd_data;

  logic          draining;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] emit_n;
  logic [5:0]    sum_rate;
  logic          sum_sec;
  logic [1:0]    sum_stat;

  logic          s1_valid;
  logic          s1_kind;
  logic [5:0]    s1_rate;
  logic          s1_sec;
  logic [5:0]    s1_len;
  logic [1:0]    s1_stat;

  logic          out_valid;
  logic          out_kind;
  logic [7:0]    out_char;
  logic [5:0]    out_rate;
  logic          out_sec;
  logic [5:0]    out_len;
  logic [1:0]    out_stat;
  logic          out_last;

  logic          in_acc;
  logic          wr_en;
  logic          issue;
  logic          issue_char;
  logic          out_load;
  logic [1:0]    end_stat;
  logic [CW-1:0] n_raw;
  logic [CW-1:0] n_clamp;

  wies_step u_step (
    .cur        (run),
    .b          (in_ch.elem_byte),
    .vendor_oui (vendor_oui),
    .id_limit   (id_limit),
    .nxt        (run_next),
    .op         (op)
  );

  assign in_ch.ready = !draining;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_en       = in_acc && op.ssid_take && (ssid_count < CW'(SSID_BYTES));
  assign out_load    = s1_valid && (!out_valid || out_ch.ready);
  assign issue       = draining && (!s1_valid || out_load);
  assign issue_char  = issue && (rd_idx < emit_n);

  always_comb begin
    if (op.ssid_clear) begin
      ssid_count_next = '0;
    end else if (op.ssid_take && ssid_count < CW'(SSID_BYTES)) begin
      ssid_count_next = CW'(ssid_count + 1'b1);
    end else begin
      ssid_count_next = ssid_count;
    end
    if (run_next.stopped) begin
      end_stat = STAT_STOP;
    end else if (run_next.phase == PHASE_LEN || run_next.phase == PHASE_DATA) begin
      end_stat = STAT_OPEN;
    end else begin
      end_stat = STAT_OK;
    end
    if (end_stat == STAT_OPEN && run_next.phase == PHASE_DATA &&
        run_next.cur_id == ID_SSID) begin
      n_raw = '0;
    end else begin
      n_raw = ssid_count_next;
    end
    n_clamp = (n_raw > CW'(EMIT_MAX)) ? CW'(EMIT_MAX) : n_raw;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_oui <= OUI_RESET;
      id_limit   <= LIMIT_RESET;
      run        <= RUN_RESET;
      ssid_count <= '0;
      draining   <= 1'b0;
      rd_idx     <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_OUI:   vendor_oui <= cfg_data[23:0];
          CFG_LIMIT: id_limit   <= cfg_data[7:0];
          default:   ;
        endcase
      end
      if (in_acc) begin
        if (in_ch.list_end) begin
          run        <= RUN_RESET;
          ssid_count <= '0;
          draining   <= 1'b1;
          rd_idx     <= '0;
        end else begin
          run        <= run_next;
          ssid_count <= ssid_count_next;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
        if (issue_char) begin
          rd_idx <= CW'(rd_idx + 1'b1);
        end else begin
          draining <= 1'b0;
        end
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ssid store and result payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ssid_count[AW-1:0]] <= in_ch.elem_byte;
    end
    if (issue_char) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
    if (in_acc && in_ch.list_end) begin
      emit_n   <= n_clamp;
      sum_rate <= run_next.comm_rate;
      sum_sec  <= run_next.security;
      sum_stat <= end_stat;
    end
    if (issue) begin
      s1_kind <= issue_char ? KIND_CHAR : KIND_SUM;
      s1_rate <= sum_rate;
      s1_sec  <= sum_sec;
      s1_len  <= 6'(emit_n);
      s1_stat <= sum_stat;
    end
    if (out_load) begin
      out_kind <= s1_kind;
      if (s1_kind == KIND_CHAR) begin
        out_char <= rd_data;
        out_rate <= 6'd0;
        out_sec  <= 1'b0;
        out_len  <= 6'd0;
        out_stat <= STAT_OK;
        out_last <= 1'b0;
      end else begin
        out_char <= 8'd0;
        out_rate <= s1_rate;
        out_sec  <= s1_sec;
        out_len  <= s1_len;
        out_stat <= s1_stat;
        out_last <= 1'b1;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.item_kind    = out_kind;
  assign out_ch.ssid_char    = out_char;
  assign out_ch.best_rate    = out_rate;
  assign out_ch.has_security = out_sec;
  assign out_ch.ssid_length  = out_len;
  assign out_ch.parse_status = out_stat;
  assign out_ch.run_last     = out_last;

endmodule

// ----- hw/rtl/wies_check.sv -----
module wies_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_list_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic       item_kind,
  input logic [7:0] ssid_char,
  input logic [5:0] best_rate,
  input logic       has_security,
  input logic [5:0] ssid_length,
  input logic [1:0] parse_status,
  input logic       run_last
);
  import wies_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_CHAR |->
      !run_last && best_rate == 6'd0 && !has_security && ssid_length == 6'd0 &&
      parse_status == STAT_OK)
    else $error("character word carries summary fields");

  a_sum_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_SUM |->
      run_last && ssid_char == 8'd0 && ssid_length <= 6'd32 && parse_status != 2'd3)
    else $error("malformed summary word");

  a_end_pause: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_list_end |=> !in_ready)
    else $error("input not held off after end of list");

endmodule

bind wifi_info_element_scanner_top wies_check u_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_list_end  (in_ch.list_end),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .item_kind    (out_ch.item_kind),
  .ssid_char    (out_ch.ssid_char),
  .best_rate    (out_ch.best_rate),
  .has_security (out_ch.has_security),
  .ssid_length  (out_ch.ssid_length),
  .parse_status (out_ch.parse_status),
  .run_last     (out_ch.run_last)
);
